[src/assert_macros.svh]
// assertion helpers for the level meter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define FLM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("flm: assertion failed");
// antecedent this cycle, consequent in the next cycle
`define FLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flm: assertion failed");
`else
`define FLM_ASSERT(label, clk, rst_n, prop)
`define FLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/flm_pkg.sv]
`timescale 1ns / 1ps
package flm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ENERGY_W = 41;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned LEVEL_W  = 10;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned RATE_W   = 16;

    // config port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'b1;

    localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST = 11'd640;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST  = 16'd16000;

    localparam logic [9:0]         MS_PER_S  = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1023;

    // back end iteration
    localparam int unsigned QUOT_W     = 42;
    localparam int unsigned ROOT_W     = QUOT_W / 2;
    localparam int unsigned SREM_W     = ROOT_W + 2;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned DIV_STEPS  = QUOT_W;
    localparam int unsigned SQRT_STEPS = ROOT_W;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_bk_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bk_status;

endpackage

[src/flm_in_if.sv]
`timescale 1ns / 1ps
interface flm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [flm_pkg::SAMPLE_W-1:0] sample;
    logic                                frame_end;
    logic                                stream_start;

    modport source (output valid, output sample, output frame_end, output stream_start,
                    input ready);
    modport sink (input valid, input sample, input frame_end, input stream_start,
                  output ready);
endinterface

[src/flm_out_if.sv]
`timescale 1ns / 1ps
interface flm_out_if;
    logic                         valid;
    logic                         ready;
    logic [flm_pkg::LEVEL_W-1:0]  level;
    logic [flm_pkg::MS_W-1:0]     elapsed_ms;

    modport source (output valid, output level, output elapsed_ms, input ready);
    modport sink (input valid, input level, input elapsed_ms, output ready);
endinterface

[src/flm_front.sv]
`timescale 1ns / 1ps
module flm_front #(
    parameter int MAX_FRAME = 1024,
    parameter int CNT_W     = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    flm_in_if.sink                       i_smp,
    input  logic [flm_pkg::LEN_W-1:0]    i_frame_length,
    output logic                         o_push_valid,
    output logic [flm_pkg::ENERGY_W-1:0] o_push_energy,
    output logic [CNT_W-1:0]             o_push_count,
    output logic [flm_pkg::TOTAL_W-1:0]  o_push_total,
    input  logic                         i_push_ready
);

    logic [flm_pkg::ENERGY_W-1:0] r_energy;
    logic [CNT_W-1:0]             r_count;
    logic [flm_pkg::TOTAL_W-1:0]  r_total;

    logic                         w_accept;
    logic [flm_pkg::ENERGY_W-1:0] w_base_e;
    logic [CNT_W-1:0]             w_base_c;
    logic [flm_pkg::TOTAL_W-1:0]  w_base_t;
    logic [flm_pkg::SAMPLE_W-1:0] w_mag;
    logic [2*flm_pkg::SAMPLE_W-1:0] w_sq;
    logic [flm_pkg::ENERGY_W:0]   w_sum;
    logic [flm_pkg::ENERGY_W-1:0] n_energy;
    logic [CNT_W-1:0]             n_count;
    logic [flm_pkg::TOTAL_W-1:0]  n_total;
    logic [CNT_W-1:0]             w_eff_len;
    logic                         w_close;

    assign i_smp.ready = i_push_ready;
    assign w_accept    = i_smp.valid && i_smp.ready;

    always_comb begin
        // stream start wipes the running state before this sample counts
        w_base_e = i_smp.stream_start ? '0 : r_energy;
        w_base_c = i_smp.stream_start ? '0 : r_count;
        w_base_t = i_smp.stream_start ? '0 : r_total;

        w_mag = i_smp.sample[flm_pkg::SAMPLE_W-1] ? (~i_smp.sample + 1'b1) : i_smp.sample;
        w_sq  = w_mag * w_mag;
        w_sum = {1'b0, w_base_e}
              + {{(flm_pkg::ENERGY_W + 1 - 2*flm_pkg::SAMPLE_W){1'b0}}, w_sq};
        n_energy = w_sum[flm_pkg::ENERGY_W] ? '1 : w_sum[flm_pkg::ENERGY_W-1:0];
        n_count  = w_base_c + 1'b1;
        n_total  = (&w_base_t) ? w_base_t : w_base_t + 1'b1;

        if (i_frame_length == '0) begin
            w_eff_len = CNT_W'(1);
        end else if (32'(i_frame_length) > 32'(MAX_FRAME)) begin
            w_eff_len = CNT_W'(MAX_FRAME);
        end else begin
            w_eff_len = CNT_W'(i_frame_length);
        end

        w_close = i_smp.frame_end || (n_count >= w_eff_len);
    end

    assign o_push_valid  = w_accept && w_close;
    assign o_push_energy = n_energy;
    assign o_push_count  = n_count;
    assign o_push_total  = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_count  <= '0;
            r_total  <= '0;
        end else if (w_accept) begin
            r_total <= n_total;
            if (w_close) begin
                r_energy <= '0;
                r_count  <= '0;
            end else begin
                r_energy <= n_energy;
                r_count  <= n_count;
            end
        end
    end

endmodule

[src/flm_queue.sv]
`timescale 1ns / 1ps
module flm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    input  logic [W-1:0] i_push_data,
    output logic         o_push_ready,
    output logic         o_pop_valid,
    output logic [W-1:0] o_pop_data,
    input  logic         i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]     r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_fill != (PTR_W+1)'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[src/flm_back.sv]
`timescale 1ns / 1ps
module flm_back #(
    parameter int CNT_W = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  logic [flm_pkg::ENERGY_W-1:0] i_job_energy,
    input  logic [CNT_W-1:0]             i_job_count,
    input  logic [flm_pkg::TOTAL_W-1:0]  i_job_total,
    output logic                         o_job_ready,
    input  logic [flm_pkg::RATE_W-1:0]   i_sample_rate,
    output flm_pkg::t_bk_status          o_status,
    flm_out_if.source                    o_lvl
);

    localparam int QW = flm_pkg::QUOT_W;
    localparam int RW = flm_pkg::ROOT_W;
    localparam int SW = flm_pkg::SREM_W;
    localparam int MW = flm_pkg::RATE_W;

    flm_pkg::t_bk_state r_state;
    flm_pkg::t_bk_state n_state;

    logic [flm_pkg::STEP_W-1:0] r_step;
    logic [QW-1:0]              r_edq;
    logic [CNT_W-1:0]           r_erem;
    logic [CNT_W-1:0]           r_cnt;
    logic [QW-1:0]              r_mdq;
    logic [MW-1:0]              r_mrem;
    logic [flm_pkg::TOTAL_W-1:0] r_tot;
    logic [SW-1:0]              r_srem;
    logic [RW-1:0]              r_root;
    logic                       r_out_valid;
    logic [flm_pkg::LEVEL_W-1:0] r_level;
    logic [flm_pkg::MS_W-1:0]   r_ms;

    logic              w_load_out;
    logic              w_last_div;
    logic              w_last_sqrt;
    logic [QW-1:0]     w_prod;
    logic [CNT_W:0]    w_e_trial;
    logic [CNT_W:0]    w_e_diff;
    logic              w_e_ge;
    logic [MW:0]       w_m_trial;
    logic [MW:0]       w_m_diff;
    logic              w_m_ge;
    logic [SW+1:0]     w_s_trial;
    logic [SW+1:0]     w_s_test;
    logic [SW+1:0]     w_s_diff;
    logic              w_s_ge;

    assign w_last_div  = (r_step == flm_pkg::STEP_W'(flm_pkg::DIV_STEPS - 1));
    assign w_last_sqrt = (r_step == flm_pkg::STEP_W'(flm_pkg::SQRT_STEPS - 1));
    assign w_prod      = r_tot * flm_pkg::MS_PER_S;

    // one restoring step of each divider and of the square root
    always_comb begin
        w_e_trial = {r_erem, r_edq[QW-1]};
        w_e_ge    = (w_e_trial >= {1'b0, r_cnt});
        w_e_diff  = w_e_trial - {1'b0, r_cnt};
        w_m_trial = {r_mrem, r_mdq[QW-1]};
        w_m_ge    = (w_m_trial >= {1'b0, i_sample_rate});
        w_m_diff  = w_m_trial - {1'b0, i_sample_rate};
        w_s_trial = {r_srem, r_edq[QW-1 -: 2]};
        w_s_test  = {2'b00, r_root, 2'b01};
        w_s_ge    = (w_s_trial >= w_s_test);
        w_s_diff  = w_s_trial - w_s_test;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            flm_pkg::BK_IDLE: if (i_job_valid) n_state = flm_pkg::BK_MUL;
            flm_pkg::BK_MUL:  n_state = flm_pkg::BK_DIV;
            flm_pkg::BK_DIV:  if (w_last_div) n_state = flm_pkg::BK_SQRT;
            flm_pkg::BK_SQRT: if (w_last_sqrt) n_state = flm_pkg::BK_DONE;
            flm_pkg::BK_DONE: if (w_load_out) n_state = flm_pkg::BK_IDLE;
            default:          n_state = flm_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready   = (r_state == flm_pkg::BK_IDLE);
        w_load_out    = (r_state == flm_pkg::BK_DONE) && (!r_out_valid || o_lvl.ready);
        o_status.busy = (r_state != flm_pkg::BK_IDLE);
        o_status.done = (r_state == flm_pkg::BK_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flm_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_lvl.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            flm_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    r_edq  <= {{(QW - flm_pkg::ENERGY_W){1'b0}}, i_job_energy};
                    r_erem <= '0;
                    r_cnt  <= i_job_count;
                    r_tot  <= i_job_total;
                end
            end
            flm_pkg::BK_MUL: begin
                r_mdq  <= w_prod;
                r_mrem <= '0;
                r_step <= '0;
            end
            flm_pkg::BK_DIV: begin
                r_edq  <= {r_edq[QW-2:0], w_e_ge};
                r_erem <= w_e_ge ? w_e_diff[CNT_W-1:0] : w_e_trial[CNT_W-1:0];
                r_mdq  <= {r_mdq[QW-2:0], w_m_ge};
                r_mrem <= w_m_ge ? w_m_diff[MW-1:0] : w_m_trial[MW-1:0];
                if (w_last_div) begin
                    r_step <= '0;
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            flm_pkg::BK_SQRT: begin
                // energy quotient shifts out two bits per root digit
                r_edq  <= {r_edq[QW-3:0], 2'b00};
                r_srem <= w_s_ge ? w_s_diff[SW-1:0] : w_s_trial[SW-1:0];
                r_root <= {r_root[RW-2:0], w_s_ge};
                r_step <= r_step + 1'b1;
            end
            default: begin
                if (w_load_out) begin
                    r_level <= (|r_root[RW-1:flm_pkg::LEVEL_W+4]) ? flm_pkg::LEVEL_MAX
                                                                  : r_root[flm_pkg::LEVEL_W+3:4];
                    r_ms    <= (|r_mdq[QW-1:flm_pkg::MS_W]) ? '1 : r_mdq[flm_pkg::MS_W-1:0];
                end
            end
        endcase
    end

    assign o_lvl.valid      = r_out_valid;
    assign o_lvl.level      = r_level;
    assign o_lvl.elapsed_ms = r_ms;

endmodule

[src/frame_rms_level_meter_unit.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// frame rms level meter
//
// i_smp carries one signed 16-bit pcm sample per transfer, with frame_end and
// stream_start flags. the front end squares and accumulates each sample in the
// cycle of its transfer, so samples stream in at one per cycle while the queue
// has room. a frame closes after frame_length samples or on frame_end; the
// closing sample pushes the frame (energy, sample count, total samples) into a
// two-entry queue. the back end takes one frame at a time: it takes the frame,
// forms the total samples times 1000 product, runs bit-serial division (energy
// by count and product by sample rate, side by side), then the square root,
// then loads the output register that offers the result transfer on o_lvl.
// the back end takes no new frame until its result is loaded; with short
// frames the queue fills and i_smp.ready drops until a slot frees.
// a stalled o_lvl holds its result; the back end then waits in its last step,
// and samples keep flowing until the queue is full.
// reset clears the running sums, the queue and the output valid, and sets
// frame_length to 640 and sample_rate to 16000. config writes go through
// i_cfg_we / i_cfg_idx / i_cfg_data and take effect on the next cycle.
module frame_rms_level_meter_unit #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    flm_in_if.sink                           i_smp,
    flm_out_if.source                        o_lvl,
    input  logic                             i_cfg_we,
    input  logic [flm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [flm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // frame count has to hold the largest frame itself
    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int JOB_W = flm_pkg::ENERGY_W + CNT_W + flm_pkg::TOTAL_W;
    localparam int QUEUE_DEPTH = 2;

    // config registers
    logic [flm_pkg::LEN_W-1:0]  r_frame_length;
    logic [flm_pkg::RATE_W-1:0] r_sample_rate;

    // front to queue
    logic                         w_push_valid;
    logic                         w_push_ready;
    logic [flm_pkg::ENERGY_W-1:0] w_push_energy;
    logic [CNT_W-1:0]             w_push_count;
    logic [flm_pkg::TOTAL_W-1:0]  w_push_total;

    // queue to back
    logic             w_job_valid;
    logic             w_job_ready;
    logic [JOB_W-1:0] w_job_data;

    flm_pkg::t_bk_status w_bk_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= flm_pkg::FRAME_LENGTH_RST;
            r_sample_rate  <= flm_pkg::SAMPLE_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flm_pkg::CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[flm_pkg::LEN_W-1:0];
                flm_pkg::CFG_SAMPLE_RATE:  r_sample_rate  <= i_cfg_data[flm_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulate and close frames
    flm_front #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_smp          (i_smp),
        .i_frame_length (r_frame_length),
        .o_push_valid   (w_push_valid),
        .o_push_energy  (w_push_energy),
        .o_push_count   (w_push_count),
        .o_push_total   (w_push_total),
        .i_push_ready   (w_push_ready)
    );

    // closed frames wait here while the back end iterates
    flm_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  ({w_push_energy, w_push_count, w_push_total}),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_job_valid),
        .o_pop_data   (w_job_data),
        .i_pop_ready  (w_job_ready)
    );

    // divide, root and elapsed time
    flm_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job_energy  (w_job_data[JOB_W-1 -: flm_pkg::ENERGY_W]),
        .i_job_count   (w_job_data[flm_pkg::TOTAL_W +: CNT_W]),
        .i_job_total   (w_job_data[flm_pkg::TOTAL_W-1:0]),
        .o_job_ready   (w_job_ready),
        .i_sample_rate (r_sample_rate),
        .o_status      (w_bk_status),
        .o_lvl         (o_lvl)
    );

    // a closing sample never finds the queue full
    `FLM_ASSERT(a_no_queue_overflow, i_clk, i_rst_n, w_push_valid |-> w_push_ready)
    // taking a frame starts the back end
    `FLM_ASSERT_NEXT(a_job_starts_back, i_clk, i_rst_n, w_job_valid && w_job_ready, w_bk_status.busy)
    // a new result only appears out of the final back end step
    `FLM_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(o_lvl.valid) |-> $past(w_bk_status.done))

endmodule
